// ----- src/cave_pkg.sv -----
// ----------------------------------------------------------------------------
// cave_pkg
// Shared types and constants for the cave automaton row step block.
// ----------------------------------------------------------------------------
package cave_pkg;

  localparam int MAX_SIZE   = 64;
  localparam int MIN_SIZE   = 8;
  localparam int ROW_W      = MAX_SIZE;
  localparam int ROWNUM_W   = $clog2(MAX_SIZE);
  localparam int SIZE_W     = 7;
  localparam int LIMIT_W    = 4;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SIZE_W;
  localparam int OUT_DEPTH  = 3;
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIRTH_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEATH_LIMIT = 2'd2;

  localparam logic [SIZE_W-1:0]  GRID_SIZE_RST   = 7'd64;
  localparam logic [LIMIT_W-1:0] BIRTH_LIMIT_RST = 4'd4;
  localparam logic [LIMIT_W-1:0] DEATH_LIMIT_RST = 4'd3;

  typedef struct packed {
    logic [LIMIT_W-1:0] birth;
    logic [LIMIT_W-1:0] death;
  } cave_limits_t;

  typedef struct packed {
    logic [ROW_W-1:0]    next_row_cells;
    logic [ROWNUM_W-1:0] row_number;
    logic                frame_last;
  } cave_result_t;

endpackage

// ----- src/cave_if.sv -----
// ----------------------------------------------------------------------------
// cave_if
// Valid/ready channels for incoming grid rows and outgoing result rows.
// ----------------------------------------------------------------------------
interface cave_in_if;
  logic                        valid;
  logic                        ready;
  logic [cave_pkg::ROW_W-1:0]  row_cells;

  modport source (output valid, output row_cells, input ready);
  modport sink   (input valid, input row_cells, output ready);
endinterface

interface cave_out_if;
  logic                          valid;
  logic                          ready;
  logic [cave_pkg::ROW_W-1:0]    next_row_cells;
  logic [cave_pkg::ROWNUM_W-1:0] row_number;
  logic                          frame_last;

  modport source (output valid, output next_row_cells, output row_number,
                  output frame_last, input ready);
  modport sink   (input valid, input next_row_cells, input row_number,
                  input frame_last, output ready);
endinterface

// ----- src/cave_automaton_row_step.sv -----
// ----------------------------------------------------------------------------
// cave_automaton_row_step
// One generation of the birth/death cave automaton, one grid row per item.
//
//   channel | direction | payload
//   in_row  | sink      | row_cells
//   out_row | source    | next_row_cells, row_number, frame_last
//   cfg_*   | write     | grid_size, birth_limit, death_limit
//
// A row is taken every cycle while the output queue has room; its results
// are computed in the cycle of acceptance by two rows of 64 cell lanes and
// are registered into a three-entry output queue. The final row of a
// frame yields two items; the queue absorbs the extra one, and the first
// row of the next frame yields none, so input never pauses on its own.
// Synchronous reset clears the configuration to defaults and empties the
// row history and queue. A stalled output backs up into in_row.ready.
// ----------------------------------------------------------------------------
module cave_automaton_row_step (
  input  logic                           clk,
  input  logic                           rst_n,
  cave_in_if.sink                        in_row,
  cave_out_if.source                     out_row,
  input  logic                           cfg_we,
  input  logic [cave_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cave_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [cave_pkg::SIZE_W-1:0]   grid_size_r;
  logic [cave_pkg::LIMIT_W-1:0]  birth_limit_r;
  logic [cave_pkg::LIMIT_W-1:0]  death_limit_r;
  logic [cave_pkg::ROW_W-1:0]    row_above_r;
  logic [cave_pkg::ROW_W-1:0]    row_middle_r;
  logic [cave_pkg::ROWNUM_W-1:0] rows_rcvd_r;

  logic [cave_pkg::SIZE_W-1:0]   eff_size;
  logic [cave_pkg::ROWNUM_W-1:0] size_m1;
  logic [cave_pkg::ROWNUM_W-1:0] size_m2;
  logic [cave_pkg::ROW_W-1:0]    lane_en;
  logic [cave_pkg::ROW_W-1:0]    row_in;
  logic [cave_pkg::ROW_W-1:0]    next_a;
  logic [cave_pkg::ROW_W-1:0]    next_b;
  cave_pkg::cave_limits_t        limits;
  cave_pkg::cave_result_t        res0;
  cave_pkg::cave_result_t        res1;
  logic                          in_acc;
  logic                          first_row;
  logic                          last_row;
  logic                          room;

  // Effective size is clamped to the supported range.
  always_comb begin
    eff_size = grid_size_r;
    if (grid_size_r < cave_pkg::SIZE_W'(cave_pkg::MIN_SIZE)) begin
      eff_size = cave_pkg::SIZE_W'(cave_pkg::MIN_SIZE);
    end else if (grid_size_r > cave_pkg::SIZE_W'(cave_pkg::MAX_SIZE)) begin
      eff_size = cave_pkg::SIZE_W'(cave_pkg::MAX_SIZE);
    end
    for (int x = 0; x < cave_pkg::ROW_W; x++) begin
      lane_en[x] = (cave_pkg::SIZE_W'(x) < eff_size);
    end
  end

  assign size_m1 = cave_pkg::ROWNUM_W'(eff_size - cave_pkg::SIZE_W'(1));
  assign size_m2 = cave_pkg::ROWNUM_W'(eff_size - cave_pkg::SIZE_W'(2));

  assign limits.birth = birth_limit_r;
  assign limits.death = death_limit_r;

  assign row_in    = in_row.row_cells & lane_en;
  assign in_row.ready = room;
  assign in_acc    = in_row.valid && room;
  assign first_row = (rows_rcvd_r == '0);
  // A size shrunk mid-frame can leave the count past the end; treat as last.
  assign last_row  = !first_row && (rows_rcvd_r >= size_m1);

  cave_row_eval u_eval_a (
    .row_up   (row_above_r),
    .row_mid  (row_middle_r),
    .row_dn   (row_in),
    .lane_en  (lane_en),
    .limits   (limits),
    .row_next (next_a)
  );

  cave_row_eval u_eval_b (
    .row_up   (row_middle_r),
    .row_mid  (row_in),
    .row_dn   ('0),
    .lane_en  (lane_en),
    .limits   (limits),
    .row_next (next_b)
  );

  always_comb begin
    res0.next_row_cells = next_a;
    res0.row_number     = last_row ? size_m2
                                   : rows_rcvd_r - cave_pkg::ROWNUM_W'(1);
    res0.frame_last     = 1'b0;
    res1.next_row_cells = next_b;
    res1.row_number     = size_m1;
    res1.frame_last     = 1'b1;
  end

  cave_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_acc && !first_row),
    .push_two (last_row),
    .push_d0  (res0),
    .push_d1  (res1),
    .room     (room),
    .out_row  (out_row)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r   <= cave_pkg::GRID_SIZE_RST;
      birth_limit_r <= cave_pkg::BIRTH_LIMIT_RST;
      death_limit_r <= cave_pkg::DEATH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cave_pkg::REG_GRID_SIZE:   grid_size_r   <= cfg_wdata;
        cave_pkg::REG_BIRTH_LIMIT: birth_limit_r <= cfg_wdata[cave_pkg::LIMIT_W-1:0];
        cave_pkg::REG_DEATH_LIMIT: death_limit_r <= cfg_wdata[cave_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_above_r  <= '0;
      row_middle_r <= '0;
      rows_rcvd_r  <= '0;
    end else if (in_acc) begin
      if (last_row) begin
        row_above_r  <= '0;
        row_middle_r <= '0;
        rows_rcvd_r  <= '0;
      end else begin
        row_above_r  <= first_row ? '0 : row_middle_r;
        row_middle_r <= row_in;
        rows_rcvd_r  <= rows_rcvd_r + cave_pkg::ROWNUM_W'(1);
      end
    end
  end

endmodule

// ----- src/cave_cell_lane.sv -----
// ----------------------------------------------------------------------------
// cave_cell_lane
// One cell: counts live neighbors and applies the birth and death rule.
// ----------------------------------------------------------------------------
module cave_cell_lane (
  input  logic [7:0]             nbr,
  input  logic                   self_alive,
  input  cave_pkg::cave_limits_t limits,
  output logic                   alive
);

  logic [cave_pkg::CNT_W-1:0] cnt;

  always_comb begin
    cnt = '0;
    for (int k = 0; k < 8; k++) begin
      cnt = cnt + {{(cave_pkg::CNT_W-1){1'b0}}, nbr[k]};
    end
  end

  // Limits are compared as given, so out-of-range values simply never match.
  assign alive = self_alive ? (cnt >= limits.death) : (cnt > limits.birth);

endmodule

// ----- src/cave_row_eval.sv -----
// ----------------------------------------------------------------------------
// cave_row_eval
// A full row of cell lanes side by side, merged into one masked result row.
// ----------------------------------------------------------------------------
module cave_row_eval (
  input  logic [cave_pkg::ROW_W-1:0] row_up,
  input  logic [cave_pkg::ROW_W-1:0] row_mid,
  input  logic [cave_pkg::ROW_W-1:0] row_dn,
  input  logic [cave_pkg::ROW_W-1:0] lane_en,
  input  cave_pkg::cave_limits_t     limits,
  output logic [cave_pkg::ROW_W-1:0] row_next
);

  // One dead cell of padding on each side handles the grid edges.
  logic [cave_pkg::ROW_W+1:0] up_p;
  logic [cave_pkg::ROW_W+1:0] mid_p;
  logic [cave_pkg::ROW_W+1:0] dn_p;
  logic [cave_pkg::ROW_W-1:0] lane_out;

  // Cells beyond the grid read as dead, including bits kept from a larger size.
  assign up_p  = {1'b0, row_up  & lane_en, 1'b0};
  assign mid_p = {1'b0, row_mid & lane_en, 1'b0};
  assign dn_p  = {1'b0, row_dn  & lane_en, 1'b0};

  for (genvar x = 0; x < cave_pkg::ROW_W; x++) begin : g_lane
    cave_cell_lane u_lane (
      .nbr        ({up_p[x], up_p[x+1], up_p[x+2], mid_p[x], mid_p[x+2],
                    dn_p[x], dn_p[x+1], dn_p[x+2]}),
      .self_alive (mid_p[x+1]),
      .limits     (limits),
      .alive      (lane_out[x])
    );
  end

  assign row_next = lane_out & lane_en;

endmodule

// ----- src/cave_out_queue.sv -----
// ----------------------------------------------------------------------------
// cave_out_queue
// Small shifting result queue; takes one or two items per cycle and
// presents the oldest on the output channel.
// ----------------------------------------------------------------------------
module cave_out_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic                   push_two,
  input  cave_pkg::cave_result_t push_d0,
  input  cave_pkg::cave_result_t push_d1,
  output logic                   room,
  cave_out_if.source             out_row
);

  cave_pkg::cave_result_t             q_r   [cave_pkg::OUT_DEPTH];
  cave_pkg::cave_result_t             q_nxt [cave_pkg::OUT_DEPTH];
  logic [cave_pkg::OUT_CNT_W-1:0]     cnt_r;
  logic [cave_pkg::OUT_CNT_W-1:0]     cnt_nxt;
  logic [cave_pkg::OUT_CNT_W-1:0]     base;
  logic [cave_pkg::OUT_CNT_W-1:0]     base_p1;
  logic                               pop;

  assign out_row.valid          = (cnt_r != '0);
  assign out_row.next_row_cells = q_r[0].next_row_cells;
  assign out_row.row_number     = q_r[0].row_number;
  assign out_row.frame_last     = q_r[0].frame_last;

  assign pop  = out_row.valid && out_row.ready;

  assign base    = cnt_r - {{(cave_pkg::OUT_CNT_W-1){1'b0}}, pop};
  assign base_p1 = base + cave_pkg::OUT_CNT_W'(1);

  // Room for two items once this cycle's drain is counted.
  assign room = (base <= cave_pkg::OUT_CNT_W'(1));

  always_comb begin
    for (int i = 0; i < cave_pkg::OUT_DEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < cave_pkg::OUT_DEPTH - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
    end
    for (int i = 0; i < cave_pkg::OUT_DEPTH; i++) begin
      if (push && (base == cave_pkg::OUT_CNT_W'(i))) begin
        q_nxt[i] = push_d0;
      end else if (push && push_two && (base_p1 == cave_pkg::OUT_CNT_W'(i))) begin
        q_nxt[i] = push_d1;
      end
    end
    cnt_nxt = base;
    if (push) begin
      cnt_nxt = push_two ? base + cave_pkg::OUT_CNT_W'(2) : base_p1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < cave_pkg::OUT_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- sim/cave_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// cave_tb_pkg
// Next-generation predictor and result scoreboard for the cave automaton
// row step. Input rows are noted as they are accepted, and each output item
// is compared with the oldest predicted row.
// ----------------------------------------------------------------------------
package cave_tb_pkg;

  import cave_pkg::*;

  class cave_generation_scoreboard;

    logic [SIZE_W-1:0]  grid_size;
    logic [LIMIT_W-1:0] birth_limit;
    logic [LIMIT_W-1:0] death_limit;

    logic [ROW_W-1:0]   row_above;
    logic [ROW_W-1:0]   row_middle;
    int unsigned        rows_in_frame;

    cave_result_t       predicted_rows[$];

    int unsigned        mismatches;
    int unsigned        rows_checked;
    int unsigned        frames_closed;

    function new();
      grid_size     = GRID_SIZE_RST;
      birth_limit   = BIRTH_LIMIT_RST;
      death_limit   = DEATH_LIMIT_RST;
      row_above     = '0;
      row_middle    = '0;
      rows_in_frame = 0;
      mismatches    = 0;
      rows_checked  = 0;
      frames_closed = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GRID_SIZE:   grid_size   = data[SIZE_W-1:0];
        REG_BIRTH_LIMIT: birth_limit = data[LIMIT_W-1:0];
        REG_DEATH_LIMIT: death_limit = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // Sizes outside the supported range are clamped, not rejected.
    function int unsigned size_in_use();
      if (grid_size < MIN_SIZE) return MIN_SIZE;
      if (grid_size > MAX_SIZE) return MAX_SIZE;
      return grid_size;
    endfunction

    function logic [ROW_W-1:0] evolve_row(input logic [ROW_W-1:0] up, input logic [ROW_W-1:0] mid,
                                          input logic [ROW_W-1:0] down, input int unsigned n);
      logic [ROW_W-1:0] res;
      int               cnt;
      int               xx;
      res = '0;
      for (int x = 0; x < int'(n); x++) begin
        cnt = 0;
        for (int dx = -1; dx <= 1; dx++) begin
          xx = x + dx;
          if (xx >= 0 && xx < int'(n)) begin
            cnt += up[xx] + down[xx];
            if (dx != 0) cnt += mid[xx];
          end
        end
        if (mid[x]) res[x] = (cnt >= int'(death_limit));
        else        res[x] = (cnt > int'(birth_limit));
      end
      return res;
    endfunction

    function void note_row(input logic [ROW_W-1:0] cells);
      int unsigned      n;
      logic [ROW_W-1:0] mask;
      logic [ROW_W-1:0] row;
      cave_result_t     res;
      n    = size_in_use();
      mask = (n >= ROW_W) ? '1 : ((64'd1 << n) - 64'd1);
      row  = cells & mask;
      if (rows_in_frame == 0) begin
        row_above     = '0;
        row_middle    = row;
        rows_in_frame = 1;
      end else if (rows_in_frame < n - 1) begin
        res.next_row_cells = evolve_row(row_above, row_middle, row, n) & mask;
        res.row_number     = ROWNUM_W'(rows_in_frame - 1);
        res.frame_last     = 1'b0;
        predicted_rows.push_back(res);
        row_above     = row_middle;
        row_middle    = row;
        rows_in_frame = rows_in_frame + 1;
      end else begin
        // Also covers a size that shrank below the rows already held: the
        // incoming row closes the frame at the new size.
        res.next_row_cells = evolve_row(row_above, row_middle, row, n) & mask;
        res.row_number     = ROWNUM_W'(n - 2);
        res.frame_last     = 1'b0;
        predicted_rows.push_back(res);
        res.next_row_cells = evolve_row(row_middle, row, '0, n) & mask;
        res.row_number     = ROWNUM_W'(n - 1);
        res.frame_last     = 1'b1;
        predicted_rows.push_back(res);
        row_above     = '0;
        row_middle    = '0;
        rows_in_frame = 0;
      end
    endfunction

    function void check_result(input logic [ROW_W-1:0] cells, input logic [ROWNUM_W-1:0] rownum,
                               input logic last);
      cave_result_t want;
      if (predicted_rows.size() == 0) begin
        $error("result row %0d arrived with no prediction waiting", rownum);
        mismatches++;
        return;
      end
      want = predicted_rows.pop_front();
      rows_checked++;
      if (want.frame_last) frames_closed++;
      if (cells !== want.next_row_cells) begin
        $error("next_row_cells: expected %h, got %h", want.next_row_cells, cells);
        mismatches++;
      end
      if (rownum !== want.row_number) begin
        $error("row_number: expected %0d, got %0d", want.row_number, rownum);
        mismatches++;
      end
      if (last !== want.frame_last) begin
        $error("frame_last: expected %0b, got %0b", want.frame_last, last);
        mismatches++;
      end
    endfunction

  endclass

endpackage

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Regression for cave_automaton_row_step. Grid rows are streamed in bursts
// under a varying output stall pattern, across many grid sizes and birth and
// death limits; every output item is checked against a cycle-free model.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import cave_pkg::*;
  import cave_tb_pkg::*;

  localparam int unsigned RANDOM_ROWS   = 1600;
  localparam int unsigned SETTLE_CYCLES = 8;
  // The slowest correct run streams its rows in bursts with sender gaps and
  // its results behind heavy receiver stalls, plus drains; the limit leaves a
  // wide margin.
  localparam int unsigned CYCLE_LIMIT   = 500_000;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_PATTERN, RX_HEAVY} rx_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cave_in_if  in_ch ();
  cave_out_if out_ch ();

  cave_automaton_row_step u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_row   (in_ch),
    .out_row  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  cave_generation_scoreboard sb;

  bit [31:0]   cycle_count;
  rx_mode_t    rx_mode;
  int unsigned burst_left;
  int unsigned rows_sent;
  int unsigned settings_used;

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_GRID_SIZE;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.row_cells = '0;
    out_ch.ready = 1'b1;
    cycle_count  = 0;
    rx_mode      = RX_OPEN;
  end

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cave_automaton_row_step regression: fail");
      $finish;
    end
  end

  // The receiver switches between stall styles at regular intervals.
  always @(posedge clk) begin
    if (cycle_count[6:0] == 7'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:    out_ch.ready <= 1'b1;
      RX_LIGHT:   out_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_PATTERN: out_ch.ready <= (cycle_count[2:0] != 3'd5) &&
                                  !(cycle_count[5:4] == 2'b11 && cycle_count[0]);
      default:    out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Inputs are noted before outputs that are taken in the same cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_row(in_ch.row_cells);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.next_row_cells, out_ch.row_number, out_ch.frame_last);
    end
  end

  task automatic send_row(input logic [ROW_W-1:0] cells);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.row_cells <= cells;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    rows_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.predicted_rows.size() != 0);
    // The first row of a frame yields nothing, so give the block time to settle.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [SIZE_W-1:0] size,
                                input logic [CFG_DATA_W-1:0] birth_word,
                                input logic [CFG_DATA_W-1:0] death_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GRID_SIZE;
    cfg_wdata <= size;
    sb.set_reg(REG_GRID_SIZE, size);
    @(posedge clk);
    cfg_index <= REG_BIRTH_LIMIT;
    cfg_wdata <= birth_word;
    sb.set_reg(REG_BIRTH_LIMIT, birth_word);
    @(posedge clk);
    cfg_index <= REG_DEATH_LIMIT;
    cfg_wdata <= death_word;
    sb.set_reg(REG_DEATH_LIMIT, death_word);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [ROW_W-1:0] random_row();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    a = {$urandom(), $urandom()};
    b = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0:       return a & b;
      1:       return a | b;
      2:       return '0;
      3:       return '1;
      4:       return a & (b | {$urandom(), $urandom()});
      default: return a;
    endcase
  endfunction

  initial begin
    int unsigned      phase;
    int unsigned      n;
    int unsigned      count;
    int unsigned      first_random;
    logic [SIZE_W-1:0]  size;
    logic [LIMIT_W-1:0] birth;
    logic [LIMIT_W-1:0] death;

    sb            = new();
    burst_left    = 0;
    rows_sent     = 0;
    settings_used = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, then the size drops to 8 with ten rows already held.
    send_row('1);
    send_row('0);
    for (int i = 0; i < 8; i++) send_row(random_row());
    wait_drained();
    apply_settings(7'd8, 7'd4, 7'd3);
    send_row(random_row());
    wait_drained();

    // Smallest grid with solid, striped, edge and out-of-lane rows.
    send_row('1);
    send_row('0);
    send_row(64'hAAAA_AAAA_AAAA_AAAA);
    send_row(64'h5555_5555_5555_5555);
    send_row(64'h0000_0000_0000_0001);
    send_row(64'h0000_0000_0000_0080);
    send_row(64'h8000_0000_0000_0100);
    send_row('1);
    wait_drained();

    phase = 0;
    first_random = rows_sent;
    while (rows_sent - first_random < RANDOM_ROWS) begin
      case ($urandom_range(0, 9))
        0:       size = SIZE_W'($urandom_range(0, 7));
        1:       size = 7'd64;
        2:       size = SIZE_W'($urandom_range(65, 127));
        3:       size = 7'd8;
        4:       size = SIZE_W'($urandom_range(33, 63));
        default: size = SIZE_W'($urandom_range(9, 24));
      endcase
      case ($urandom_range(0, 5))
        0:       birth = 4'd0;
        1:       birth = 4'd8;
        2:       birth = LIMIT_W'($urandom_range(9, 15));
        default: birth = LIMIT_W'($urandom_range(0, 8));
      endcase
      case ($urandom_range(0, 5))
        0:       death = 4'd0;
        1:       death = 4'd9;
        2:       death = LIMIT_W'($urandom_range(10, 15));
        default: death = LIMIT_W'($urandom_range(0, 9));
      endcase
      // The first few settings pin the limit and size extremes.
      case (phase)
        0: begin birth = 4'd0;  death = 4'd0;  end
        1: begin birth = 4'd15; death = 4'd15; end
        2: size = 7'd127;
        3: size = 7'd0;
        default: ;
      endcase
      apply_settings(size, {3'($urandom_range(0, 7)), birth}, {3'($urandom_range(0, 7)), death});
      n = sb.size_in_use();
      // Mostly whole frames; now and then a frame cut short, which the next
      // setting then finishes at another size.
      if ($urandom_range(0, 7) == 0) count = $urandom_range(1, n);
      else if (sb.rows_in_frame >= n - 1) count = 1 + $urandom_range(0, 2) * n;
      else count = (n - sb.rows_in_frame) + $urandom_range(0, 2) * n;
      for (int i = 0; i < int'(count); i++) send_row(random_row());
      wait_drained();
      phase++;
    end

    $display("Streamed %0d grid rows under %0d register settings; checked %0d output rows",
             rows_sent, settings_used, sb.rows_checked);
    $display("closing %0d frames, with sizes clamped, shrunk mid-frame and limits at their extremes.",
             sb.frames_closed);
    if (sb.mismatches == 0) begin
      $display("cave_automaton_row_step regression: pass");
    end else begin
      $display("cave_automaton_row_step regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/cave_pkg.sv
src/cave_if.sv
src/cave_cell_lane.sv
src/cave_row_eval.sv
src/cave_out_queue.sv
src/cave_automaton_row_step.sv
sim/cave_tb_pkg.sv
sim/testbench.sv
